FILE: rtl/swkth_pkg.sv
// shared types and constants for the sliding window k-th smallest filter
`default_nettype none

package swkth_pkg;

    // default sizing
    localparam int DEF_WINDOW      = 16;
    localparam int DEF_SAMPLE_BITS = 16;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 5;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RANK_K     = CFG_IDX_W'(1);

    localparam logic [CFG_W-1:0] WLEN_RST = CFG_W'(16);
    localparam logic [CFG_W-1:0] RANK_RST = CFG_W'(8);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAND,
        ST_SWEEP,
        ST_DRAIN,
        ST_EVAL,
        ST_DONE
    } state_t;

    // what the last ram read was issued for
    typedef enum logic [1:0] {
        RD_NONE,
        RD_CAND,
        RD_CMP
    } rd_tag_t;

    typedef struct packed {
        logic in_ready;
        logic cand_issue;
        logic cmp_issue;
        logic next_cand;
        logic load_out;
    } swkth_cmd_t;

    typedef struct packed {
        logic full_after;
        logic last_j;
        logic last_i;
        logic hit;
        logic out_free;
    } swkth_stat_t;

endpackage

`default_nettype wire

FILE: rtl/swkth_ram.sv
// generic single write, single registered read ram
`default_nettype none

module swkth_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/swkth_ctrl.sv
// controller state machine for the rank search
`default_nettype none

module swkth_ctrl
    import swkth_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire swkth_stat_t stat,
    output swkth_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && stat.full_after) begin
                    state_next = ST_CAND;
                end
            end
            ST_CAND: begin
                state_next = ST_SWEEP;
            end
            ST_SWEEP: begin
                if (stat.last_j) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (stat.hit || stat.last_i) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_CAND;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:  cmd.in_ready   = 1'b1;
            ST_CAND:  cmd.cand_issue = 1'b1;
            ST_SWEEP: cmd.cmp_issue  = 1'b1;
            ST_DRAIN: cmd            = '0;
            ST_EVAL:  cmd.next_cand  = !stat.hit;
            ST_DONE:  cmd.load_out   = stat.out_free;
            default:  cmd            = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/swkth_dp.sv
// datapath: sample store, config registers, rank counter and output register
`default_nettype none

module swkth_dp
    import swkth_pkg::*;
#(
    parameter int WINDOW      = DEF_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    input  wire logic signed [SAMPLE_BITS-1:0] s_sample,
    input  wire logic                          m_ready,
    output logic                               m_valid,
    output logic signed      [SAMPLE_BITS-1:0] m_kth_value,
    input  wire logic                          cfg_valid,
    input  wire logic        [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic        [CFG_W-1:0]       cfg_data,
    input  wire swkth_cmd_t                    cmd,
    output swkth_stat_t                        stat
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);

    logic [CFG_W-1:0] wlen_reg;
    logic [CFG_W-1:0] rank_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [IDX_W-1:0] oldest_reg;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] jd_reg;
    logic [CNT_W-1:0] cnt_reg;
    rd_tag_t          tag_reg;
    logic signed [SAMPLE_BITS-1:0] cand_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;
    logic                          m_valid_reg;

    logic [CNT_W-1:0] w_eff;
    logic [CNT_W-1:0] k_eff;
    logic [IDX_W-1:0] wr_slot;
    logic [IDX_W-1:0] oldest_next;
    logic [IDX_W-1:0] raddr;
    logic [SAMPLE_BITS-1:0] rdata_raw;
    logic signed [SAMPLE_BITS-1:0] rdata;
    logic             accept;
    logic             cfg_wlen;
    logic             less;

    // effective window length and rank after clamping
    always_comb begin
        if (wlen_reg == '0) begin
            w_eff = CNT_W'(1);
        end else if (32'(wlen_reg) > WINDOW) begin
            w_eff = CNT_W'(WINDOW);
        end else begin
            w_eff = CNT_W'(wlen_reg);
        end
        if (rank_reg == '0) begin
            k_eff = CNT_W'(1);
        end else if (32'(rank_reg) > 32'(w_eff)) begin
            k_eff = w_eff;
        end else begin
            k_eff = CNT_W'(rank_reg);
        end
    end

    assign accept   = cmd.in_ready && s_valid;
    assign cfg_wlen = cfg_valid && (cfg_index == REG_WINDOW_LEN);

    always_comb begin
        wr_slot = (CNT_W'(oldest_reg) >= w_eff) ? '0 : oldest_reg;
        if ((CNT_W'(wr_slot) + CNT_W'(1)) >= w_eff) begin
            oldest_next = '0;
        end else begin
            oldest_next = wr_slot + IDX_W'(1);
        end
    end

    assign raddr = cmd.cand_issue ? i_reg : j_reg;

    swkth_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW)
    ) u_store (
        .aclk  (aclk),
        .wr_en (accept),
        .waddr (wr_slot),
        .wdata (s_sample),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign rdata = $signed(rdata_raw);

    // stored sample orders below the candidate: smaller, or equal in a lower slot
    assign less = (rdata < cand_reg) || ((rdata == cand_reg) && (jd_reg < i_reg));

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wlen_reg    <= WLEN_RST;
            rank_reg    <= RANK_RST;
            fill_reg    <= '0;
            oldest_reg  <= '0;
            tag_reg     <= RD_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wlen) begin
                wlen_reg   <= cfg_data;
                fill_reg   <= '0;
                oldest_reg <= '0;
            end else if (accept) begin
                oldest_reg <= oldest_next;
                if (fill_reg < w_eff) begin
                    fill_reg <= fill_reg + CNT_W'(1);
                end
            end
            if (cfg_valid && (cfg_index == REG_RANK_K)) begin
                rank_reg <= cfg_data;
            end
            if (cmd.cand_issue) begin
                tag_reg <= RD_CAND;
            end else if (cmd.cmp_issue) begin
                tag_reg <= RD_CMP;
            end else begin
                tag_reg <= RD_NONE;
            end
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // search datapath
    always_ff @(posedge aclk) begin
        if (accept) begin
            i_reg <= '0;
        end else if (cmd.next_cand) begin
            i_reg <= i_reg + IDX_W'(1);
        end
        if (cmd.cand_issue) begin
            j_reg   <= '0;
            cnt_reg <= '0;
        end else if (cmd.cmp_issue) begin
            j_reg <= j_reg + IDX_W'(1);
        end
        jd_reg <= j_reg;
        unique case (tag_reg)
            RD_CAND: cand_reg <= rdata;
            RD_CMP: begin
                if (less) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
        if (cmd.load_out) begin
            out_reg <= cand_reg;
        end
    end

    always_comb begin
        stat.full_after = (fill_reg >= (w_eff - CNT_W'(1)));
        stat.last_j     = (CNT_W'(j_reg) == (w_eff - CNT_W'(1)));
        stat.last_i     = (CNT_W'(i_reg) == (w_eff - CNT_W'(1)));
        stat.hit        = (cnt_reg == (k_eff - CNT_W'(1)));
        stat.out_free   = !m_valid_reg || m_ready;
    end

    assign m_valid     = m_valid_reg;
    assign m_kth_value = out_reg;

endmodule

`default_nettype wire

FILE: rtl/sliding_window_kth_smallest.sv
// result: none for a sample that arrives while the window is still filling; otherwise the
//   search tries from 1 to w candidate slots, w the window length, until the k-th
//   ranked one is found, and then loads the result register
// throughput: one sample per cycle while filling; a sample that fills the window holds
//   off the next transfer until its search ends, longer while a result waits
// reset: synchronous active low; window empty, window_len 16, rank_k 8
`default_nettype none

module sliding_window_kth_smallest
    import swkth_pkg::*;
#(
    parameter int WINDOW      = DEF_WINDOW,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // sample input channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] s_sample,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed      [SAMPLE_BITS-1:0] m_kth_value,
    // configuration write channel
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic        [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic        [CFG_W-1:0]       cfg_data
);

    swkth_cmd_t  cmd;
    swkth_stat_t stat;

    // register writes are taken in any cycle; a window_len write restarts the fill
    assign cfg_ready = 1'b1;

    // sample transfers are taken only in idle; the result register lets the
    // next sample in while the previous result still waits for its transfer
    assign s_ready = cmd.in_ready;

    // sequencer: write sample, then for each candidate slot sweep the window,
    // counting entries ranked below it, until the count equals rank_k - 1
    swkth_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .stat    (stat),
        .cmd     (cmd)
    );

    // sample store, clamped config, rank counter and output register
    swkth_dp #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_sample    (s_sample),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_kth_value (m_kth_value),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire

FILE: rtl/swkth_checker.sv
// port-level checker for the sliding window k-th smallest filter, with its bind
`default_nettype none

module swkth_checker
    import swkth_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_valid,
    input wire logic                   s_ready,
    input wire logic                   m_valid,
    input wire logic                   m_ready,
    input wire logic [SAMPLE_BITS-1:0] m_kth_value
);

    // no result pending right after reset
    a_rst_no_result: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // block comes out of reset ready for samples
    a_rst_ready: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kth_value))
        else $error("stalled result changed");

    // a new result is only produced while the search holds off new samples
    a_new_result_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !$past(m_valid)) |-> !$past(s_ready))
        else $error("result appeared while idle");

    // an offered sample stays offered until its transfer
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("sample withdrawn before transfer");

endmodule

bind sliding_window_kth_smallest swkth_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_swkth_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_kth_value (m_kth_value)
);

`default_nettype wire

FILE: tb/sliding_window_kth_smallest_tb.sv
// self-checking testbench for the sliding window k-th smallest filter
`timescale 1ns / 1ps

module sliding_window_kth_smallest_tb;
    import swkth_pkg::*;

    localparam int WINDOW      = DEF_WINDOW;
    localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
    // worst case for one sample: every candidate tried over the full window
    localparam int SETTLE_CYCLES = WINDOW * (WINDOW + 3) + 8;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_ITEMS  = 450;
    localparam int MAX_WAIT      = 11;
    // index with no register behind it, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic [CFG_W-1:0]              cfg_word_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    sample_t              s_sample  = '0;
    logic                 m_ready   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_WINDOW_LEN;
    cfg_word_t            cfg_data  = '0;
    logic                 s_ready;
    logic                 m_valid;
    sample_t              m_kth_value;
    logic                 cfg_ready;

    // own copy of the filter state and its two registers
    sample_t     win_store [WINDOW];
    int unsigned fill_level = 0;
    int unsigned next_slot  = 0;
    cfg_word_t   wlen_reg   = WLEN_RST;
    cfg_word_t   rank_reg   = RANK_RST;

    // k-th values still owed by the block, oldest first
    sample_t kth_expected [$];

    bit idle_on     = 1'b0;
    int fail_count  = 0;
    int items_sent  = 0;
    int cycle_count = 0;

    always #5 aclk = ~aclk;

    sliding_window_kth_smallest u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kth_value (m_kth_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // window length as the block uses it: zero counts as one, large values clip
    function automatic int unsigned span_of(input cfg_word_t wl);
        if (wl == 0) return 1;
        if (wl > WINDOW) return WINDOW;
        return wl;
    endfunction

    // store one sample; once the window is full, owe the k-th smallest of it
    function automatic void predict_kth(input sample_t v);
        int unsigned w;
        int unsigned k;
        sample_t     ordered [WINDOW];
        sample_t     hold_val;
        int          i;
        int          j;
        w = span_of(wlen_reg);
        k = rank_reg;
        if (next_slot >= w) next_slot = 0;
        win_store[next_slot] = v;
        next_slot++;
        if (next_slot >= w) next_slot = 0;
        if (fill_level < w) fill_level++;
        // still filling, nothing comes out
        if (fill_level < w) return;
        if (k == 0) k = 1;
        if (k > w) k = w;
        // ties do not change the value at a given rank, so a plain sort will do
        for (i = 0; i < w; i++) ordered[i] = win_store[i];
        for (i = 1; i < w; i++) begin
            hold_val = ordered[i];
            j = i - 1;
            while (j >= 0 && ordered[j] > hold_val) begin
                ordered[j + 1] = ordered[j];
                j--;
            end
            ordered[j + 1] = hold_val;
        end
        kth_expected.push_back(ordered[k - 1]);
    endfunction

    // mix of full-range values, a narrow band for duplicates, and the extremes
    function automatic sample_t pick_sample();
        int unsigned mode;
        mode = $urandom_range(0, 9);
        if (mode < 5) return sample_t'($urandom);
        if (mode < 8) return sample_t'(int'($urandom_range(0, 6)) - 3);
        case ($urandom_range(0, 3))
            0: return sample_t'(-32768);
            1: return sample_t'(32767);
            2: return sample_t'(-1);
            default: return sample_t'(0);
        endcase
    endfunction

    // one sample transfer; entered and left at a rising edge
    task automatic send_sample(input sample_t v);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= v;
        do @(posedge aclk); while (!(s_valid && s_ready));
        items_sent++;
        predict_kth(v);
    endtask

    // one register write; hold keeps valid up for a write right behind it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input cfg_word_t data,
                             input bit hold = 1'b0);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        if (!hold) cfg_valid <= 1'b0;
        if (idx == REG_WINDOW_LEN) begin
            // a new length empties the window
            wlen_reg   = data;
            fill_level = 0;
            next_slot  = 0;
        end else if (idx == REG_RANK_K) begin
            rank_reg = data;
        end
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        while (kth_expected.size() != 0) @(posedge aclk);
    endtask

    // a sample that fills nothing may still be in flight, give it time
    task automatic quiesce();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input cfg_word_t wl, input cfg_word_t rk);
        quiesce();
        write_reg(REG_WINDOW_LEN, wl, 1'b1);
        write_reg(REG_RANK_K, rk);
    endtask

    // reset settings: full 16-deep window, median-ish rank, extremes and ties
    task automatic test_defaults();
        sample_t seq [17];
        seq = '{-32768, 32767, 0, -1, 1, 5, 5, 5, -5, 100, -100, 32767, -32768,
                7, 7, 0, 3};
        idle_on = 1'b1;
        foreach (seq[i]) send_sample(seq[i]);
    endtask

    // zero length acts as one, zero rank as the smallest
    task automatic test_zero_settings();
        configure(cfg_word_t'(0), cfg_word_t'(0));
        send_sample(sample_t'(-32768));
        send_sample(sample_t'(32767));
        send_sample(sample_t'(-1));
    endtask

    // rank beyond the window clips to the largest
    task automatic test_rank_over_window();
        configure(cfg_word_t'(3), cfg_word_t'(31));
        send_sample(sample_t'(0));
        send_sample(sample_t'(-32768));
        send_sample(sample_t'(32767));
        send_sample(sample_t'(12));
    endtask

    // write to an index with no register: window and rank stay as they were
    task automatic test_unused_register();
        quiesce();
        write_reg(REG_UNUSED, cfg_word_t'(5'h1f));
        send_sample(sample_t'(-7));
    endtask

    // sender holds off until every owed result is out, then a burst with no gaps
    task automatic test_drain_pause();
        configure(cfg_word_t'(4), cfg_word_t'(2));
        idle_on = 1'b1;
        repeat (6) send_sample(pick_sample());
        wait_results();
        idle_on = 1'b0;
        repeat (6) send_sample(pick_sample());
    endtask

    // phases of random settings, mostly short windows since long ones are slow
    task automatic test_random_phases();
        int          phase;
        int          pick;
        int          len;
        int unsigned span;
        cfg_word_t   wl;
        cfg_word_t   rk;
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (phase == 0)      wl = cfg_word_t'(31);
            else if (phase == 1) wl = cfg_word_t'(16);
            else if (pick < 14)  wl = cfg_word_t'($urandom_range(1, 6));
            else if (pick < 16)  wl = cfg_word_t'($urandom_range(7, 15));
            else if (pick == 16) wl = cfg_word_t'(16);
            else if (pick == 17) wl = cfg_word_t'($urandom_range(17, 31));
            else if (pick == 18) wl = cfg_word_t'(0);
            else                 wl = cfg_word_t'($urandom_range(1, 3));
            span = span_of(wl);
            pick = $urandom_range(0, 9);
            if (phase == 0)      rk = cfg_word_t'(1);
            else if (phase == 1) rk = cfg_word_t'(16);
            else if (pick == 0)  rk = cfg_word_t'(0);
            else if (pick == 1)  rk = cfg_word_t'($urandom_range(17, 31));
            else                 rk = cfg_word_t'($urandom_range(1, span));
            configure(wl, rk);
            idle_on = ($urandom_range(0, 3) != 0);
            len = span + $urandom_range(4, 24);
            for (int n = 0; n < len; n++) begin
                send_sample(pick_sample());
                // rank change on a full window, takes effect on the next sample
                if (n > span && $urandom_range(0, 15) == 0) begin
                    quiesce();
                    write_reg(REG_RANK_K, cfg_word_t'($urandom_range(0, 31)));
                end
            end
            phase++;
        end
    endtask

    // receiver: random stall before each result, none while idling is off
    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            stall = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // every result transfer is matched against the oldest owed value
    always @(posedge aclk) begin
        sample_t want;
        if (aresetn && m_valid && m_ready) begin
            if (kth_expected.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result transfer: kth_value %0d at cycle %0d",
                             m_kth_value, cycle_count);
            end else begin
                want = kth_expected.pop_front();
                if (m_kth_value !== want) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("kth_value mismatch at cycle %0d: expected %0d, got %0d",
                                 cycle_count, want, m_kth_value);
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sliding_window_kth_smallest_tb: errors");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_defaults();
        test_zero_settings();
        test_rank_over_window();
        test_unused_register();
        test_drain_pause();
        test_random_phases();
        // let everything owed arrive, then watch for stray results
        quiesce();
        if (fail_count == 0) begin
            $display("sliding_window_kth_smallest_tb: clean");
        end else begin
            $display("sliding_window_kth_smallest_tb: errors");
        end
        $finish;
    end

endmodule
